// ===== rtl/bgd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bgd_pkg;

  // Field widths fixed by the interface
  localparam int KEY_W    = 3;
  localparam int KIND_W   = 2;
  localparam int TICK_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Register reset values and the tick counter limit
  localparam logic [TICK_W-1:0] CLICK_MAX_RST  = 16'h2500;
  localparam logic [TICK_W-1:0] DOUBLE_GAP_RST = 16'h0050;
  localparam logic [TICK_W-1:0] LONG_PRESS_RST = 16'h4000;
  localparam logic [TICK_W-1:0] REPEAT_RST     = 16'h0500;
  localparam logic [TICK_W-1:0] TICK_MAX       = 16'hffff;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLICK_MAX    = 3'd0,
    REG_DOUBLE_GAP   = 3'd1,
    REG_LONG_PRESS   = 3'd2,
    REG_REPEAT       = 3'd3,
    REG_DOUBLE_EN    = 3'd4
  } cfg_reg_t;

  // Event codes
  typedef enum logic [KIND_W-1:0] {
    EV_CLICK  = 2'd0,
    EV_DOUBLE = 2'd1,
    EV_LONG   = 2'd2,
    EV_REPEAT = 2'd3
  } ev_kind_t;

  // Per-key gesture state, one-hot
  typedef enum logic [4:0] {
    GS_IDLE   = 5'b00001,
    GS_PRESS  = 5'b00010,
    GS_HELD   = 5'b00100,
    GS_GAP    = 5'b01000,
    GS_SECOND = 5'b10000
  } gest_state_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    logic             key_pressed;
  } in_req_t;

  typedef struct packed {
    logic [KEY_W-1:0]  event_key;
    logic [KIND_W-1:0] event_kind;
  } out_req_t;

  typedef struct packed {
    logic [TICK_W-1:0] click_max;
    logic [TICK_W-1:0] double_gap;
    logic [TICK_W-1:0] long_press;
    logic [TICK_W-1:0] repeat_ivl;
    logic              double_en;
  } cfg_t;

  typedef struct packed {
    gest_state_t       gst;
    logic [TICK_W-1:0] press_ticks;
    logic [TICK_W-1:0] gap_ticks;
    logic [TICK_W-1:0] second_ticks;
  } key_rec_t;

  // Result of one gesture update
  typedef struct packed {
    logic     fire;
    ev_kind_t kind;
  } step_evt_t;

endpackage

`default_nettype wire

// ===== rtl/button_gesture_detector.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_req  (key_index, key_pressed)
// out_      output     out_valid/out_stall out_evt (event_key, event_kind)
// cfg_      input      cfg_we             cfg_index, cfg_wdata
//
// One sample per cycle sustained while the input does not stall: a sample is
// registered, then its key's record is updated and any event goes to the
// output register, from which the event is valid.
// Synchronous reset puts every key idle with zeroed counters and loads the
// register defaults. A stalled output holds the event; input stalls only
// when a pending sample has an event and the output register stays full.

module button_gesture_detector
  import bgd_pkg::*;
#(
  parameter int NUM_KEYS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_req,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_req_t              out_evt,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Only keys that the 3-bit index can reach need storage
  localparam int MAX_KEYS = 1 << KEY_W;
  localparam int SLOTS    = (NUM_KEYS < MAX_KEYS) ? NUM_KEYS : MAX_KEYS;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  cfg_t      cfg_r;
  logic      in_valid_r;
  in_req_t   in_req_r;
  logic      out_valid_r;
  out_req_t  out_evt_r;

  logic             key_ok;
  logic [IDX_W-1:0] key_idx;
  key_rec_t         cur_rec;
  key_rec_t         nxt_rec;
  step_evt_t        evt;
  logic             out_free;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.click_max  <= CLICK_MAX_RST;
      cfg_r.double_gap <= DOUBLE_GAP_RST;
      cfg_r.long_press <= LONG_PRESS_RST;
      cfg_r.repeat_ivl <= REPEAT_RST;
      cfg_r.double_en  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CLICK_MAX:  cfg_r.click_max  <= cfg_wdata;
        REG_DOUBLE_GAP: cfg_r.double_gap <= cfg_wdata;
        REG_LONG_PRESS: cfg_r.long_press <= cfg_wdata;
        REG_REPEAT:     cfg_r.repeat_ivl <= cfg_wdata;
        REG_DOUBLE_EN:  cfg_r.double_en  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Pending sample: key indexes of NUM_KEYS and above are dropped with no effect
  assign key_ok  = (32'(in_req_r.key_index) < NUM_KEYS);
  assign key_idx = IDX_W'(in_req_r.key_index);

  bgd_key_bank #(
    .SLOTS (SLOTS)
  ) u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_idx (key_idx),
    .rd_rec (cur_rec),
    .wr_en  (advance && key_ok),
    .wr_idx (key_idx),
    .wr_rec (nxt_rec)
  );

  bgd_step u_step (
    .cur     (cur_rec),
    .pressed (in_req_r.key_pressed),
    .cfg     (cfg_r),
    .nxt     (nxt_rec),
    .evt     (evt)
  );

  // Sample retires unless its event cannot enter the output register
  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && (!(evt.fire && key_ok) || out_free);
  assign in_stall = in_valid_r && !advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_req_r <= in_req;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= advance && evt.fire && key_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && advance && evt.fire && key_ok) begin
      out_evt_r.event_key  <= in_req_r.key_index;
      out_evt_r.event_kind <= evt.kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_evt   = out_evt_r;

endmodule

`default_nettype wire

// ===== rtl/bgd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_step
  import bgd_pkg::*;
(
  input  key_rec_t  cur,
  input  logic      pressed,
  input  cfg_t      cfg,
  output key_rec_t  nxt,
  output step_evt_t evt
);

  logic [TICK_W-1:0] press_inc;
  logic [TICK_W-1:0] gap_inc;
  logic [TICK_W-1:0] second_inc;

  // Saturating tick counters
  assign press_inc  = (cur.press_ticks == TICK_MAX) ? cur.press_ticks :
                      cur.press_ticks + 1'b1;
  assign gap_inc    = (cur.gap_ticks == TICK_MAX) ? cur.gap_ticks :
                      cur.gap_ticks + 1'b1;
  assign second_inc = (cur.second_ticks == TICK_MAX) ? cur.second_ticks :
                      cur.second_ticks + 1'b1;

  // Gesture transitions
  always_comb begin
    nxt      = cur;
    evt.fire = 1'b0;
    evt.kind = EV_CLICK;
    case (cur.gst)
      GS_IDLE: begin
        if (pressed) begin
          nxt.press_ticks = '0;
          nxt.gst         = GS_PRESS;
        end
      end
      GS_PRESS: begin
        if (pressed) begin
          nxt.press_ticks = press_inc;
          if (press_inc >= cfg.long_press) begin
            nxt.press_ticks = '0;
            nxt.gst         = GS_HELD;
            evt.fire        = 1'b1;
            evt.kind        = EV_LONG;
          end
        end else if (cur.press_ticks > cfg.click_max) begin
          nxt.gst = GS_IDLE;
        end else begin
          nxt.gap_ticks = '0;
          nxt.gst       = GS_GAP;
        end
      end
      GS_HELD: begin
        if (pressed) begin
          nxt.press_ticks = press_inc;
          if (press_inc >= cfg.repeat_ivl) begin
            nxt.press_ticks = '0;
            evt.fire        = 1'b1;
            evt.kind        = EV_REPEAT;
          end
        end else begin
          nxt.gst = GS_IDLE;
        end
      end
      GS_GAP: begin
        if (!pressed) begin
          nxt.gap_ticks = gap_inc;
          if (gap_inc > cfg.double_gap) begin
            nxt.gst  = GS_IDLE;
            evt.fire = 1'b1;
            evt.kind = EV_CLICK;
          end
        end else if (cfg.double_en) begin
          nxt.second_ticks = '0;
          nxt.gst          = GS_SECOND;
        end
      end
      GS_SECOND: begin
        if (pressed) begin
          nxt.second_ticks = second_inc;
        end else begin
          nxt.gst = GS_IDLE;
          if (cur.second_ticks <= cfg.click_max) begin
            evt.fire = 1'b1;
            evt.kind = EV_DOUBLE;
          end
        end
      end
      default: begin
        nxt.gst = GS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/bgd_key_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bgd_key_bank
  import bgd_pkg::*;
#(
  parameter int SLOTS = 8,
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output key_rec_t         rd_rec,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_idx,
  input  key_rec_t         wr_rec
);

  key_rec_t rec_r [SLOTS];

  // Read the addressed key's record
  assign rd_rec = rec_r[rd_idx];

  // Per-key records, all idle and zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        rec_r[i].gst          <= GS_IDLE;
        rec_r[i].press_ticks  <= '0;
        rec_r[i].gap_ticks    <= '0;
        rec_r[i].second_ticks <= '0;
      end
    end else if (wr_en) begin
      rec_r[wr_idx] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_button_gesture_detector.sv =====
`timescale 1ns / 1ps

module tb_button_gesture_detector;
  import bgd_pkg::*;

  localparam int NUM_KEYS    = 8;
  localparam int HOLD_CYCLES = 300;      // long output hold-off for the fill test
  localparam int RUN_CAP     = 100;      // longest press or release run in random traffic
  localparam int MAX_REPORTS = 10;
  localparam longint LIMIT_NS = 20_000_000;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_req_t               in_req    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_req_t              out_evt;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Expected gesture machine, one record per key
  gest_state_t       key_state  [NUM_KEYS];
  logic [TICK_W-1:0] press_cnt  [NUM_KEYS];
  logic [TICK_W-1:0] gap_cnt    [NUM_KEYS];
  logic [TICK_W-1:0] second_cnt [NUM_KEYS];
  cfg_t              cfg_copy;

  out_req_t pending_events[$];

  int  samples_sent   = 0;
  int  events_seen    = 0;
  int  n_errors       = 0;
  int  kind_count [4] = '{0, 0, 0, 0};
  int  sender_idle_pct = 0;
  int  recv_stall_pct  = 0;
  bit  mix_keys        = 1'b0;
  bit  hold_toggle     = 1'b0;
  bit  hold_seen       = 1'b0;
  int  hold_left       = 0;

  button_gesture_detector #(.NUM_KEYS(NUM_KEYS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_evt   (out_evt),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("timeout: %0d events still expected", pending_events.size());
    $display("tb_button_gesture_detector failed");
    $finish;
  end

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  // Advance one key's gesture machine; returns 1 when the sample yields an event
  function automatic logic predict_gesture(input in_req_t s, output out_req_t ev);
    int unsigned k;
    logic        fire;
    ev_kind_t    kind;
    k    = 32'(s.key_index);
    fire = 1'b0;
    kind = EV_CLICK;
    ev   = '0;
    if (k >= NUM_KEYS) return 1'b0;
    case (key_state[k])
      GS_IDLE: begin
        if (s.key_pressed) begin
          press_cnt[k] = '0;
          key_state[k] = GS_PRESS;
        end
      end
      GS_PRESS: begin
        if (s.key_pressed) begin
          if (press_cnt[k] != TICK_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
          if (press_cnt[k] >= cfg_copy.long_press) begin
            press_cnt[k] = '0;
            key_state[k] = GS_HELD;
            fire = 1'b1;
            kind = EV_LONG;
          end
        end else if (press_cnt[k] > cfg_copy.click_max) begin
          key_state[k] = GS_IDLE;
        end else begin
          gap_cnt[k]   = '0;
          key_state[k] = GS_GAP;
        end
      end
      GS_HELD: begin
        if (s.key_pressed) begin
          if (press_cnt[k] != TICK_MAX) press_cnt[k] = press_cnt[k] + 1'b1;
          if (press_cnt[k] >= cfg_copy.repeat_ivl) begin
            press_cnt[k] = '0;
            fire = 1'b1;
            kind = EV_REPEAT;
          end
        end else begin
          key_state[k] = GS_IDLE;
        end
      end
      GS_GAP: begin
        if (!s.key_pressed) begin
          if (gap_cnt[k] != TICK_MAX) gap_cnt[k] = gap_cnt[k] + 1'b1;
          if (gap_cnt[k] > cfg_copy.double_gap) begin
            key_state[k] = GS_IDLE;
            fire = 1'b1;
            kind = EV_CLICK;
          end
        end else if (cfg_copy.double_en) begin
          second_cnt[k] = '0;
          key_state[k]  = GS_SECOND;
        end
        // press with double click off: gap stays frozen
      end
      GS_SECOND: begin
        if (s.key_pressed) begin
          if (second_cnt[k] != TICK_MAX) second_cnt[k] = second_cnt[k] + 1'b1;
        end else begin
          key_state[k] = GS_IDLE;
          if (second_cnt[k] <= cfg_copy.click_max) begin
            fire = 1'b1;
            kind = EV_DOUBLE;
          end
        end
      end
      default: key_state[k] = GS_IDLE;
    endcase
    ev.event_key  = s.key_index;
    ev.event_kind = kind;
    return fire;
  endfunction

  // Event checker: every accepted event against the oldest expectation
  always @(posedge clk) begin : event_check
    out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      events_seen++;
      kind_count[out_evt.event_kind]++;
      if (pending_events.size() == 0) begin
        flag_error($sformatf("unexpected event key %0d kind %0d",
                             out_evt.event_key, out_evt.event_kind));
      end else begin
        want = pending_events.pop_front();
        if (out_evt.event_key !== want.event_key || out_evt.event_kind !== want.event_kind)
          flag_error($sformatf("event mismatch: expected key %0d kind %0d, got key %0d kind %0d",
                               want.event_key, want.event_kind,
                               out_evt.event_key, out_evt.event_kind));
      end
    end
  end

  // Output stall: random per cycle, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Send one key sample; leaves valid high so back-to-back requests need no gap
  task automatic send_sample(input logic [KEY_W-1:0] key, input logic pressed);
    in_req_t  req;
    out_req_t ev;
    req.key_index   = key;
    req.key_pressed = pressed;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    if (predict_gesture(req, ev)) pending_events.push_back(ev);
    samples_sent++;
  endtask

  // A run of identical samples, with stray samples on other keys mixed in when mix_keys is set
  task automatic send_run(input logic [KEY_W-1:0] key, input logic pressed, input int n);
    repeat (n) begin
      if (mix_keys && $urandom_range(9) == 0)
        send_sample(key ^ KEY_W'($urandom_range(1, NUM_KEYS - 1)), 1'($urandom_range(1)));
      send_sample(key, pressed);
    end
  endtask

  // Drop valid, let every expected event arrive, then cover the pipeline latency
  task automatic wait_for_events();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CLICK_MAX:  cfg_copy.click_max  = val;
      REG_DOUBLE_GAP: cfg_copy.double_gap = val;
      REG_LONG_PRESS: cfg_copy.long_press = val;
      REG_REPEAT:     cfg_copy.repeat_ivl = val;
      REG_DOUBLE_EN:  cfg_copy.double_en  = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_thresholds(input int click, input int gap, input int hold,
                                input int rep, input bit dbl_en);
    write_reg(REG_CLICK_MAX, CFG_DATA_W'(click));
    write_reg(REG_DOUBLE_GAP, CFG_DATA_W'(gap));
    write_reg(REG_LONG_PRESS, CFG_DATA_W'(hold));
    write_reg(REG_REPEAT, CFG_DATA_W'(rep));
    write_reg(REG_DOUBLE_EN, CFG_DATA_W'(dbl_en));
  endtask

  function automatic int span(input int lo, input int hi);
    int v;
    v = $urandom_range(lo, hi);
    return (v > RUN_CAP) ? RUN_CAP : v;
  endfunction

  // One gesture on one key: click, double click, hold with repeats, or noise
  task automatic play_gesture(input logic [KEY_W-1:0] key);
    int shape;
    shape = $urandom_range(9);
    if (shape < 3) begin
      send_run(key, 1'b1, span(1, cfg_copy.click_max + 2));
      send_run(key, 1'b0, span(1, cfg_copy.double_gap + 2));
    end else if (shape < 5) begin
      send_run(key, 1'b1, span(1, cfg_copy.click_max + 1));
      send_run(key, 1'b0, span(1, cfg_copy.double_gap + 1));
      send_run(key, 1'b1, span(1, cfg_copy.click_max + 2));
      send_run(key, 1'b0, span(1, cfg_copy.double_gap + 2));
    end else if (shape < 8) begin
      send_run(key, 1'b1, span(cfg_copy.long_press + 1,
                               cfg_copy.long_press + 3 * cfg_copy.repeat_ivl + 4));
      send_run(key, 1'b0, span(1, 3));
    end else begin
      repeat ($urandom_range(1, 10)) send_sample(key, 1'($urandom_range(1)));
    end
  endtask

  task automatic play_traffic(input int n_items);
    int stop_at;
    stop_at  = samples_sent + n_items;
    mix_keys = 1'b1;
    while (samples_sent < stop_at) play_gesture(KEY_W'($urandom_range(NUM_KEYS - 1)));
    mix_keys = 1'b0;
    wait_for_events();
  endtask

  task automatic set_idling(input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    recv_stall_pct  = stall_pct;
  endtask

  // ---- directed tests ----

  // Short press, then the gap runs out and a click is reported
  task automatic test_click_timeout();
    set_thresholds(2, 1, 3, 1, 1'b1);
    send_run(3'd0, 1'b1, 3);
    send_run(3'd0, 1'b0, 3);
    wait_for_events();
  endtask

  task automatic test_double_click();
    send_run(3'd7, 1'b1, 1);
    send_run(3'd7, 1'b0, 1);
    send_run(3'd7, 1'b1, 2);
    send_run(3'd7, 1'b0, 1);
    wait_for_events();
  endtask

  task automatic test_long_press_repeat();
    send_run(3'd3, 1'b1, 5);
    send_run(3'd3, 1'b0, 1);
    wait_for_events();
  endtask

  // Double click completes after the enable drops; then a press freezes the gap
  task automatic test_enable_cleared_mid_gesture();
    send_run(3'd5, 1'b1, 1);
    send_run(3'd5, 1'b0, 1);
    send_run(3'd5, 1'b1, 1);
    wait_for_events();
    write_reg(REG_DOUBLE_EN, '0);
    send_run(3'd5, 1'b0, 1);
    send_run(3'd5, 1'b1, 1);
    send_run(3'd5, 1'b0, 1);
    send_run(3'd5, 1'b1, 1);
    send_run(3'd5, 1'b0, 2);
    wait_for_events();
  endtask

  // Every held tick fires; a long output hold-off must back up into the input
  task automatic test_output_backpressure();
    set_idling(0, 0);
    set_thresholds(3, 1, 0, 0, 1'b1);
    hold_toggle = ~hold_toggle;
    send_run(3'd2, 1'b1, 40);
    send_run(3'd2, 1'b0, 1);
    wait_for_events();
  endtask

  // ---- random traffic ----

  task automatic test_default_thresholds();
    set_idling(0, 0);
    set_thresholds(int'(CLICK_MAX_RST), int'(DOUBLE_GAP_RST), int'(LONG_PRESS_RST),
                   int'(REPEAT_RST), 1'b0);
    play_traffic(100);
  endtask

  task automatic test_small_thresholds(input int idle_pct, input int stall_pct,
                                       input bit dbl_en);
    set_idling(idle_pct, stall_pct);
    set_thresholds($urandom_range(8), $urandom_range(6), $urandom_range(12),
                   $urandom_range(4), dbl_en);
    play_traffic(200);
  endtask

  task automatic test_zero_thresholds();
    set_idling(25, 25);
    set_thresholds(0, 0, 0, 0, 1'b1);
    play_traffic(150);
  endtask

  // Gap timeout unreachable, long press never fires; only double clicks leave
  task automatic test_max_thresholds();
    set_idling(0, 71);
    set_thresholds(int'(TICK_MAX), int'(TICK_MAX), int'(TICK_MAX), int'(TICK_MAX), 1'b1);
    play_traffic(80);
  endtask

  initial begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_state[k]  = GS_IDLE;
      press_cnt[k]  = '0;
      gap_cnt[k]    = '0;
      second_cnt[k] = '0;
    end
    cfg_copy = '{CLICK_MAX_RST, DOUBLE_GAP_RST, LONG_PRESS_RST, REPEAT_RST, 1'b0};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_click_timeout();
    test_double_click();
    test_long_press_repeat();
    test_enable_cleared_mid_gesture();
    test_output_backpressure();
    test_default_thresholds();
    test_small_thresholds(0, 0, 1'b1);
    test_small_thresholds(71, 0, 1'b1);
    test_small_thresholds(0, 71, 1'b0);
    test_small_thresholds(25, 25, 1'b1);
    test_zero_thresholds();
    test_max_thresholds();

    // Let any straggling event show up before the final tally
    repeat (10) @(posedge clk);
    if (pending_events.size() != 0)
      flag_error($sformatf("%0d expected events never arrived", pending_events.size()));

    $display("summary: %0d key samples, %0d events (click %0d, double %0d, long %0d, repeat %0d)",
             samples_sent, events_seen, kind_count[EV_CLICK], kind_count[EV_DOUBLE],
             kind_count[EV_LONG], kind_count[EV_REPEAT]);
    $display("summary: thresholds zero to max, double click on/off, idle and stall mixes, %0d errors",
             n_errors);
    if (n_errors == 0) begin
      $display("tb_button_gesture_detector passed");
    end else begin
      $display("tb_button_gesture_detector failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/bgd_pkg.sv
rtl/bgd_step.sv
rtl/bgd_key_bank.sv
rtl/button_gesture_detector.sv
tb/sv/tb_button_gesture_detector.sv
